[hw/rtl/lss_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_pkg: shared types and constants for the LIFO stack with search
// Command and status codes, and the control/status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package lss_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int POS_W     = 5;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_VIEW   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    push;       // store the request word on top
    logic    pop;        // drop the top entry
    logic    scan_init;  // latch the search key, rewind the scan pointer
    logic    issue;      // read the next entry from the top down
    logic    emit;       // load the result register
    status_t emit_status;
    logic    emit_data;  // result data from the read entry, else zero
    logic    emit_pos;   // result position from the read entry, else zero
    logic    emit_last;
  } ctl_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic empty;
    logic full;
    logic issue_done;  // every stored entry has been read
    logic rd_vld;      // read data holds an entry this cycle
    logic hit;         // read entry equals the search key
    logic rd_last;     // read entry is the bottom of the stack
  } sts_t;

endpackage

[hw/rtl/lss_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_ctrl: command sequencer
// Decodes each request and steps the datapath through push, pop, search
// and view, marking each result with its status and last flag.
// ----------------------------------------------------------------------------
module lss_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  lss_pkg::cmd_t  cmd,
  input  lss_pkg::sts_t  sts,
  output logic           busy,
  output lss_pkg::ctl_t  ctl
);
  import lss_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t state, state_next;
  logic   view_mode, view_mode_next;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      view_mode <= 1'b0;
    end else begin
      state     <= state_next;
      view_mode <= view_mode_next;
    end
  end

  always_comb begin
    state_next     = state;
    view_mode_next = view_mode;
    ctl            = '0;
    ctl.emit_status = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (cmd)
            CMD_PUSH: begin
              ctl.emit      = 1'b1;
              ctl.emit_last = 1'b1;
              if (sts.full) begin
                ctl.emit_status = ST_OVERFLOW;
              end else begin
                ctl.push = 1'b1;
              end
            end
            CMD_POP: begin
              ctl.emit      = 1'b1;
              ctl.emit_last = 1'b1;
              if (sts.empty) begin
                ctl.emit_status = ST_EMPTY;
              end else begin
                ctl.pop = 1'b1;
              end
            end
            CMD_SEARCH, CMD_VIEW: begin
              if (sts.empty) begin
                ctl.emit        = 1'b1;
                ctl.emit_last   = 1'b1;
                ctl.emit_status = ST_EMPTY;
              end else begin
                ctl.scan_init  = 1'b1;
                view_mode_next = (cmd == CMD_VIEW);
                state_next     = S_SCAN;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_SCAN: begin
        ctl.issue = !sts.issue_done;
        if (sts.rd_vld) begin
          if (view_mode) begin
            ctl.emit      = 1'b1;
            ctl.emit_data = 1'b1;
            ctl.emit_last = sts.rd_last;
            if (sts.rd_last) begin
              state_next = S_IDLE;
            end
          end else if (sts.hit) begin
            ctl.emit      = 1'b1;
            ctl.emit_pos  = 1'b1;
            ctl.emit_last = 1'b1;
            state_next    = S_IDLE;
          end else if (sts.rd_last) begin
            ctl.emit        = 1'b1;
            ctl.emit_last   = 1'b1;
            ctl.emit_status = ST_NOTFOUND;
            state_next      = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/lss_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_dp: stack storage and scan datapath
// Entry memory with fill count, a top-down read pointer with registered
// read data, key compare, and the result register.
// ----------------------------------------------------------------------------
module lss_dp #(
  parameter int DEPTH = lss_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  lss_pkg::ctl_t                      ctl,
  input  logic signed [lss_pkg::DATA_W-1:0]  value,
  output lss_pkg::sts_t                      sts,
  output logic                               strobe,
  output logic [lss_pkg::STATUS_W-1:0]       status,
  output logic signed [lss_pkg::DATA_W-1:0]  data,
  output logic [lss_pkg::POS_W-1:0]          position,
  output logic                               last
);
  import lss_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW = (CW + 1 > POS_W) ? CW + 1 : POS_W;

  logic [DATA_W-1:0] mem [DEPTH];

  logic [CW-1:0]     fill;
  logic [CW-1:0]     ptr;
  logic [CW-1:0]     rd_pos;
  logic              rd_vld;
  logic [DATA_W-1:0] rd_data;
  logic [DATA_W-1:0] key;
  logic [CW-1:0]     rd_addr_full;
  logic [PW-1:0]     pos_ext;

  assign rd_addr_full = fill - CW'(1) - ptr;
  assign pos_ext      = PW'(rd_pos) + PW'(1);

  assign sts.empty      = (fill == '0);
  assign sts.full       = (fill == CW'(DEPTH));
  assign sts.issue_done = (ptr == fill);
  assign sts.rd_vld     = rd_vld;
  assign sts.hit        = (rd_data == key);
  assign sts.rd_last    = (rd_pos == fill - CW'(1));

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= '0;
      ptr    <= '0;
      rd_vld <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= ctl.emit;
      rd_vld <= ctl.issue;
      if (ctl.push) begin
        fill <= fill + CW'(1);
      end else if (ctl.pop) begin
        fill <= fill - CW'(1);
      end
      if (ctl.scan_init) begin
        ptr <= '0;
      end else if (ctl.issue) begin
        ptr <= ptr + CW'(1);
      end
    end
  end

  // Entry memory, scan read port and payload registers
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[fill[AW-1:0]] <= value;
    end
    if (ctl.issue) begin
      rd_data <= mem[rd_addr_full[AW-1:0]];
      rd_pos  <= ptr;
    end
    if (ctl.scan_init) begin
      key <= value;
    end
    if (ctl.emit) begin
      status   <= ctl.emit_status;
      data     <= ctl.emit_data ? rd_data : '0;
      position <= ctl.emit_pos ? pos_ext[POS_W-1:0] : '0;
      last     <= ctl.emit_last;
    end
  end

endmodule

[hw/rtl/lifo_stack_with_search.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lifo_stack_with_search: bounded LIFO stack of signed words with search
// Push, pop, search from the top, and a top-to-bottom view of all entries.
// ----------------------------------------------------------------------------
// Using the block: a request is taken on a clock edge with start high and
// busy low. Every request gives one or more results, each shown for exactly
// one cycle with strobe high; the receiver cannot stall them, so capture
// every strobe. Push and pop answer in the cycle after the request and keep
// busy low, so they run one per cycle. Search and view walk the entry memory
// from the top, one entry read per cycle through a registered read port,
// and hold busy high until a search hits or misses at the bottom entry, or
// until a view reads the bottom entry; view strobes one result per entry in
// consecutive cycles, top first, with last on the bottom entry. A pop,
// search or view on an empty stack, and a push to a full one, answers with
// an error status and leaves busy low. Status codes: 0 ok, 1 overflow,
// 2 empty or underflow, 3 not found. Position is the 1-based depth of the
// match from the top and is cut to its port width.
// ----------------------------------------------------------------------------
module lifo_stack_with_search #(
  parameter int DEPTH = lss_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [lss_pkg::CMD_W-1:0]          cmd,
  input  logic signed [lss_pkg::DATA_W-1:0]  value,
  output logic                               strobe,
  output logic [lss_pkg::STATUS_W-1:0]       status,
  output logic signed [lss_pkg::DATA_W-1:0]  data,
  output logic [lss_pkg::POS_W-1:0]          position,
  output logic                               last
);
  import lss_pkg::*;

  ctl_t ctl;
  sts_t sts;

  // Sequencer: decode the request, step the scan, tag each result
  lss_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd_t'(cmd)),
    .sts   (sts),
    .busy  (busy),
    .ctl   (ctl)
  );

  // Storage, scan read port, compare and result register
  lss_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .value    (value),
    .sts      (sts),
    .strobe   (strobe),
    .status   (status),
    .data     (data),
    .position (position),
    .last     (last)
  );

endmodule

[bench/tb_lifo_stack_with_search.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lifo_stack_with_search: self-checking bench for the LIFO stack with search
// A mirror of the stack predicts every answer of each accepted request, and
// a monitor compares each strobed answer with the oldest one still due.
// Stimulus is a short directed pass over the corner cases (empty stack, full
// stack, extreme words, hits at top and bottom, misses, views), followed by
// random requests that swing the fill level between empty and full under
// three different idling patterns of the sender.
// ----------------------------------------------------------------------------
module tb_lifo_stack_with_search;
  import lss_pkg::*;

  localparam int STACK_DEPTH    = DEPTH_DEF;
  localparam int QUIET_LIMIT    = 1000;  // edges with no request and no answer
  localparam int TAIL_CYCLES    = 2 * STACK_DEPTH + 4;
  localparam int ITEMS_PER_PASS = 80;

  // One answer as it appears on the result ports
  typedef struct packed {
    status_t                   status;
    logic signed [DATA_W-1:0]  data;
    logic [POS_W-1:0]          position;
    logic                      last;
  } answer_t;

  // --------------------------------------------------------------------------
  // Stack mirror: holds its own copy of the entries and the fill level, works
  // out the answers of each accepted request and checks them in order.
  // --------------------------------------------------------------------------
  class stack_mirror;
    logic signed [DATA_W-1:0] words [STACK_DEPTH];
    int unsigned              fill;
    answer_t                  due_answers [$];
    int unsigned              fails;

    function new();
      fill  = 0;
      fails = 0;
    endfunction

    function void add_answer(status_t st, logic signed [DATA_W-1:0] d,
                             logic [POS_W-1:0] p, logic l);
      answer_t a;
      a.status   = st;
      a.data     = d;
      a.position = p;
      a.last     = l;
      due_answers.push_back(a);
    endfunction

    // Advance the mirror by one accepted request
    function void note_request(cmd_t op, logic signed [DATA_W-1:0] key);
      int unsigned i;
      bit          found;
      found = 1'b0;
      case (op)
        CMD_PUSH: begin
          if (fill == STACK_DEPTH) begin
            add_answer(ST_OVERFLOW, '0, '0, 1'b1);
          end else begin
            words[fill] = key;
            fill++;
            add_answer(ST_OK, '0, '0, 1'b1);
          end
        end
        CMD_POP: begin
          if (fill == 0) begin
            add_answer(ST_EMPTY, '0, '0, 1'b1);
          end else begin
            fill--;
            add_answer(ST_OK, '0, '0, 1'b1);
          end
        end
        CMD_SEARCH: begin
          if (fill == 0) begin
            add_answer(ST_EMPTY, '0, '0, 1'b1);
          end else begin
            // first match counted from the top, 1-based
            for (i = 0; i < fill && !found; i++) begin
              if (words[fill-1-i] == key) begin
                found = 1'b1;
                add_answer(ST_OK, '0, POS_W'(i + 1), 1'b1);
              end
            end
            if (!found) add_answer(ST_NOTFOUND, '0, '0, 1'b1);
          end
        end
        CMD_VIEW: begin
          if (fill == 0) begin
            add_answer(ST_EMPTY, '0, '0, 1'b1);
          end else begin
            for (i = 0; i < fill; i++)
              add_answer(ST_OK, words[fill-1-i], '0, (i + 1 == fill));
          end
        end
      endcase
    endfunction

    // Compare one strobed answer with the oldest one due
    function void check_answer(logic [STATUS_W-1:0] st, logic signed [DATA_W-1:0] d,
                               logic [POS_W-1:0] p, logic l);
      answer_t want;
      if (due_answers.size() == 0) begin
        $error("answer with none due: status %0d data %0d position %0d last %0d",
               st, d, p, l);
        fails++;
      end else begin
        want = due_answers.pop_front();
        if (st !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, st);
          fails++;
        end
        if (d !== want.data) begin
          $error("data: expected %0d, got %0d", want.data, d);
          fails++;
        end
        if (p !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, p);
          fails++;
        end
        if (l !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, l);
          fails++;
        end
      end
    endfunction

    function int unsigned pending();
      return due_answers.size();
    endfunction

    // Return one of the stored words, so searches hit at every depth
    function logic signed [DATA_W-1:0] pick_stored();
      return words[$urandom_range(0, fill - 1)];
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block's ports; every input is known from time zero
  // --------------------------------------------------------------------------
  logic                       clk   = 1'b0;
  logic                       rst   = 1'b1;
  logic                       start = 1'b0;
  logic [CMD_W-1:0]           cmd   = CMD_PUSH;
  logic signed [DATA_W-1:0]   value = '0;
  logic                       busy;
  logic                       strobe;
  logic [STATUS_W-1:0]        status;
  logic signed [DATA_W-1:0]   data;
  logic [POS_W-1:0]           position;
  logic                       last;

  stack_mirror mirror;
  int          send_idle_pct = 27;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lifo_stack_with_search #(
    .DEPTH(STACK_DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .cmd      (cmd),
    .value    (value),
    .strobe   (strobe),
    .status   (status),
    .data     (data),
    .position (position),
    .last     (last)
  );

  // --------------------------------------------------------------------------
  // Monitor: everything here reads the values that stood before the edge, so
  // the order of processes within the step does not matter. Check the answer
  // first, then note a request taken on the same edge; its answers come later.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (strobe) mirror.check_answer(status, data, position, last);
      if (start && !busy) mirror.note_request(cmd_t'(cmd), value);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (start && !busy) || strobe) quiet = 0;
      else quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------

  // Idle at random, then hold the request until an edge finds busy low.
  // Return in the step of the accepting edge, so the next call can keep
  // start high without dropping it.
  task automatic send_request(cmd_t op, logic signed [DATA_W-1:0] key);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      start <= 1'b0;
      cmd   <= cmd_t'($urandom_range(0, 3));
      value <= $urandom;
      @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= op;
    value <= key;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drop start and wait until every due answer has arrived. Step past one
  // edge first, so the monitor has noted the last accepted request.
  task automatic hold_until_quiet();
    start <= 1'b0;
    @(posedge clk);
    while (mirror.pending() != 0) @(posedge clk);
  endtask

  // Small words in 30% of picks (to make duplicates and hits likely), extremes in 20%,
  // the rest fully random so every bit toggles
  function automatic logic signed [DATA_W-1:0] random_word();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 3) return DATA_W'($urandom_range(0, 7)) - DATA_W'(4);
    if (pick == 3) return {1'b1, {(DATA_W-1){1'b0}}};
    if (pick == 4) return {1'b0, {(DATA_W-1){1'b1}}};
    return $urandom;
  endfunction

  // Random requests; alternate between filling and draining stretches so the
  // fill level sweeps from empty to full and back
  task automatic run_random(int count);
    int   n;
    int   roll;
    bit   filling;
    cmd_t op;
    logic signed [DATA_W-1:0] key;
    for (n = 0; n < count; n++) begin
      filling = ((n / 24) % 2) == 0;
      roll    = $urandom_range(0, 99);
      if (filling) begin
        op = (roll < 70) ? CMD_PUSH : (roll < 80) ? CMD_POP :
             (roll < 92) ? CMD_SEARCH : CMD_VIEW;
      end else begin
        op = (roll < 10) ? CMD_PUSH : (roll < 70) ? CMD_POP :
             (roll < 90) ? CMD_SEARCH : CMD_VIEW;
      end
      key = random_word();
      // aim most searches at a stored word so hits land at every depth
      if (op == CMD_SEARCH && mirror.fill > 0 && $urandom_range(0, 99) < 65)
        key = mirror.pick_stored();
      send_request(op, key);
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int k;
    mirror = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: pop, search and view on the empty stack
    send_request(CMD_POP,    32'sd7);
    send_request(CMD_SEARCH, 32'sd0);
    send_request(CMD_VIEW,   -32'sd1);
    // Extreme words, then a hit on top, a miss, and a view of four
    send_request(CMD_PUSH,   {1'b1, {(DATA_W-1){1'b0}}});
    send_request(CMD_PUSH,   {1'b0, {(DATA_W-1){1'b1}}});
    send_request(CMD_PUSH,   32'sd0);
    send_request(CMD_PUSH,   -32'sd1);
    send_request(CMD_SEARCH, -32'sd1);
    send_request(CMD_SEARCH, 32'sd12345);
    send_request(CMD_VIEW,   32'sd0);
    send_request(CMD_POP,    32'sd0);
    // Fill to the brim, overflow once, hit the bottom entry, view it all
    for (k = 0; k < STACK_DEPTH - 3; k++)
      send_request(CMD_PUSH, DATA_W'(k * 3 + 5));
    send_request(CMD_PUSH,   32'sd99);
    send_request(CMD_SEARCH, {1'b1, {(DATA_W-1){1'b0}}});
    send_request(CMD_VIEW,   32'sd0);
    hold_until_quiet();

    // Random: sparse idling, then heavy idling, then back to back
    run_random(ITEMS_PER_PASS);
    hold_until_quiet();
    send_idle_pct = 84;
    run_random(ITEMS_PER_PASS);
    hold_until_quiet();
    send_idle_pct = 0;
    run_random(ITEMS_PER_PASS);

    // Let the last answers land, then watch a while for stray strobes
    hold_until_quiet();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mirror.fails == 0 && mirror.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
